### rtl/ffra_pkg.sv
// Shared types and status codes for the first-fit region allocator.
package ffra_pkg;

    localparam int STATUS_W = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SIZE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;   // latch request, restart scan at entry 0
        logic reload;     // reload table from new pool size
        logic set_err;    // record range-check failure as result
        logic step;       // advance scan by one entry
        logic commit;     // apply table update and record result
        logic emit;       // hand result to output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic range_bad;  // request fails its range check
        logic scan_done;  // scan hit its stop entry or ran past live entries
    } t_stat;

endpackage

### rtl/ffra_ctrl.sv
// Sequencing state machine for the first-fit region allocator.
module ffra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cfg_valid,
    input  logic            i_out_free,
    input  ffra_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_cfg_ready,
    output ffra_pkg::t_cmd  o_cmd
);
    import ffra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands; hold both channels off while in reset
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cfg_ready  = i_rst_n;
                o_cmd.reload = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.range_bad) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/ffra_dp.sv
// Free-region table, scan pointer and update logic of the region allocator.
module ffra_dp #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ADDR_BITS     = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffra_pkg::t_cmd                 i_cmd,
    output ffra_pkg::t_stat                o_stat,
    input  logic                           i_kind,
    input  logic [ADDR_BITS-1:0]           i_req_size,
    input  logic [ADDR_BITS-1:0]           i_req_addr,
    input  logic [ADDR_BITS:0]             i_pool_size,
    output logic [ffra_pkg::STATUS_W-1:0]  o_res_status,
    output logic [ADDR_BITS-1:0]           o_res_addr
);
    import ffra_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = ADDR_BITS + 1;
    localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);
    localparam logic [LW-1:0] POOL_MAX   = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [LW-1:0] LEN_ZERO   = '0;

    // Table and bookkeeping
    logic [ADDR_BITS-1:0] r_start [TABLE_ENTRIES];
    logic [LW-1:0]        r_len   [TABLE_ENTRIES];
    logic [CW-1:0]        r_count;
    logic [LW-1:0]        r_pool;

    // Request and scan registers
    logic                 r_kind;
    logic [ADDR_BITS-1:0] r_size;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CW-1:0]        r_idx;
    logic [ADDR_BITS-1:0] r_prev_start;
    logic [LW-1:0]        r_prev_len;
    logic [LW-1:0]        r_prev_end;

    logic [STATUS_W-1:0]  r_res_status;
    logic [ADDR_BITS-1:0] r_res_addr;

    logic                 w_at_end;
    logic [IW-1:0]        w_idx;
    logic [CW-1:0]        w_idx_m1;
    logic [ADDR_BITS-1:0] w_cur_start;
    logic [LW-1:0]        w_cur_len;
    logic [LW-1:0]        w_size_ext;
    logic [LW-1:0]        w_addr_ext;
    logic [LW-1:0]        w_end_req;
    logic [LW-1:0]        w_pool_sat;
    logic                 w_range_bad;
    logic [STATUS_W-1:0]  w_range_code;
    logic                 w_stop;

    logic                 c_wr_en;
    logic [IW-1:0]        c_wr_idx;
    logic [ADDR_BITS-1:0] c_wr_start;
    logic [LW-1:0]        c_wr_len;
    logic                 c_remove;
    logic                 c_insert;
    logic [STATUS_W-1:0]  c_status;
    logic [ADDR_BITS-1:0] c_addr;

    logic                 w_merge_prev;
    logic                 w_merge_next;
    logic [LW-1:0]        w_sum2;
    logic [LW-1:0]        w_sum3;
    logic [CW-1:0]        w_last;

    // Read entry under the scan pointer
    assign w_at_end    = (r_idx == r_count);
    assign w_idx       = w_at_end ? '0 : r_idx[IW-1:0];
    assign w_idx_m1    = r_idx - COUNT_ONE;
    assign w_cur_start = r_start[w_idx];
    assign w_cur_len   = r_len[w_idx];

    assign w_size_ext = {1'b0, r_size};
    assign w_addr_ext = {1'b0, r_addr};
    assign w_end_req  = w_addr_ext + w_size_ext;

    // Clamp a written pool size to 1 .. 2^ADDR_BITS
    always_comb begin
        if (i_pool_size == LEN_ZERO) begin
            w_pool_sat = LW'(1);
        end else if (i_pool_size > POOL_MAX) begin
            w_pool_sat = POOL_MAX;
        end else begin
            w_pool_sat = i_pool_size;
        end
    end

    // Range checks on the latched request
    always_comb begin
        w_range_bad  = 1'b0;
        w_range_code = ST_OK;
        if (!r_kind) begin
            if (w_size_ext >= r_pool) begin
                w_range_bad  = 1'b1;
                w_range_code = ST_SIZE;
            end
        end else if (w_addr_ext >= r_pool) begin
            w_range_bad  = 1'b1;
            w_range_code = ST_ADDR;
        end else if (w_end_req > r_pool) begin
            w_range_bad  = 1'b1;
            w_range_code = ST_SIZE;
        end
    end

    // Stop on first fitting region (allocate) or first region past the address (free)
    assign w_stop = r_kind ? ({1'b0, w_cur_start} > w_addr_ext) : (w_cur_len >= w_size_ext);

    assign o_stat.range_bad = w_range_bad;
    assign o_stat.scan_done = w_at_end || w_stop;

    // Merge terms for a free
    assign w_merge_prev = (r_idx != '0) && (r_prev_end == w_addr_ext);
    assign w_merge_next = !w_at_end && (w_end_req == {1'b0, w_cur_start});
    assign w_sum2       = r_prev_len + w_size_ext;
    assign w_sum3       = w_sum2 + w_cur_len;

    // Decide the table update at the scan stop point
    always_comb begin
        c_wr_en    = 1'b0;
        c_wr_idx   = w_idx;
        c_wr_start = w_cur_start;
        c_wr_len   = w_cur_len;
        c_remove   = 1'b0;
        c_insert   = 1'b0;
        c_status   = ST_OK;
        c_addr     = '0;
        if (!r_kind) begin
            if (w_at_end) begin
                c_status = ST_NOFIT;
            end else begin
                c_addr = w_cur_start;
                if (w_cur_len == w_size_ext) begin
                    c_remove = 1'b1;
                end else begin
                    c_wr_en    = 1'b1;
                    c_wr_start = w_cur_start + r_size;
                    c_wr_len   = w_cur_len - w_size_ext;
                end
            end
        end else if (w_merge_prev) begin
            c_wr_en    = 1'b1;
            c_wr_idx   = w_idx_m1[IW-1:0];
            c_wr_start = r_prev_start;
            c_wr_len   = w_merge_next ? w_sum3 : w_sum2;
            c_remove   = w_merge_next;
        end else if (w_merge_next) begin
            c_wr_en    = 1'b1;
            c_wr_start = r_addr;
            c_wr_len   = w_cur_len + w_size_ext;
        end else if (r_size == '0) begin
            c_status = ST_OK;
        end else if (r_count == COUNT_FULL) begin
            c_status = ST_FULL;
        end else begin
            c_insert = 1'b1;
        end
    end

    // Table entries: reload, write in place, or move one place down or up
    for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_entry
        logic [ADDR_BITS-1:0] w_up_start;
        logic [LW-1:0]        w_up_len;
        logic [ADDR_BITS-1:0] w_dn_start;
        logic [LW-1:0]        w_dn_len;

        if (j < TABLE_ENTRIES - 1) begin : g_up
            assign w_up_start = r_start[j+1];
            assign w_up_len   = r_len[j+1];
        end else begin : g_up_last
            assign w_up_start = '0;
            assign w_up_len   = '0;
        end

        if (j > 0) begin : g_dn
            assign w_dn_start = r_start[j-1];
            assign w_dn_len   = r_len[j-1];
        end else begin : g_dn_first
            assign w_dn_start = '0;
            assign w_dn_len   = '0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_start[j] <= '0;
                r_len[j]   <= (j == 0) ? POOL_MAX : LEN_ZERO;
            end else if (i_cmd.reload) begin
                r_start[j] <= '0;
                r_len[j]   <= (j == 0) ? w_pool_sat : LEN_ZERO;
            end else if (i_cmd.commit) begin
                if (c_wr_en && (c_wr_idx == IW'(j))) begin
                    r_start[j] <= c_wr_start;
                    r_len[j]   <= c_wr_len;
                end else if (c_remove && (r_idx <= CW'(j))) begin
                    r_start[j] <= w_up_start;
                    r_len[j]   <= w_up_len;
                end else if (c_insert && (r_idx == CW'(j))) begin
                    r_start[j] <= r_addr;
                    r_len[j]   <= w_size_ext;
                end else if (c_insert && (r_idx < CW'(j))) begin
                    r_start[j] <= w_dn_start;
                    r_len[j]   <= w_dn_len;
                end
            end
        end
    end

    // Live count and pool size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_ONE;
            r_pool  <= POOL_MAX;
        end else if (i_cmd.reload) begin
            r_count <= COUNT_ONE;
            r_pool  <= w_pool_sat;
        end else if (i_cmd.commit) begin
            if (c_remove) begin
                r_count <= r_count - COUNT_ONE;
            end else if (c_insert) begin
                r_count <= r_count + COUNT_ONE;
            end
        end
    end

    // Scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_req) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + COUNT_ONE;
        end
    end

    // Latch request, track the entry just passed, record the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind <= i_kind;
            r_size <= i_req_size;
            r_addr <= i_req_addr;
        end
        if (i_cmd.step) begin
            r_prev_start <= w_cur_start;
            r_prev_len   <= w_cur_len;
            r_prev_end   <= {1'b0, w_cur_start} + w_cur_len;
        end
        if (i_cmd.set_err) begin
            r_res_status <= w_range_code;
            r_res_addr   <= '0;
        end else if (i_cmd.commit) begin
            r_res_status <= c_status;
            r_res_addr   <= (c_status == ST_OK) ? c_addr : '0;
        end
    end

    assign o_res_status = r_res_status;
    assign o_res_addr   = r_res_addr;

    assign w_last = r_count - COUNT_ONE;

    // Live entries stay a prefix and the count stays in range
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("live count exceeds table size");

    a_prefix_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_len[w_last[IW-1:0]] != LEN_ZERO))
        else $error("last live entry has zero length");

    a_prefix_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < COUNT_FULL) |-> (r_len[r_count[IW-1:0]] == LEN_ZERO))
        else $error("entry past live count is not empty");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> ((r_res_status != ST_FULL) || $stable(r_count)))
        else $error("dropped free changed the table");

endmodule

### rtl/first_fit_region_allocator_top.sv
// Top level of the first-fit region allocator: controller, datapath, result register.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------
//  request | i_in_valid  | o_in_ready  | i_kind, i_req_size, i_req_addr
//  result  | o_out_valid | i_out_ready | o_status, o_alloc_addr
//  config  | i_cfg_valid | o_cfg_ready | i_pool_size
//
// One request at a time: accept, range check, scan one table entry per cycle,
// commit, hand-off. A range failure skips the scan and the commit.
// Reset restores one free region of 2^ADDR_BITS; a pool-size write reloads the table.
// A held result does not block the next request; a second result waits for the slot.
module first_fit_region_allocator_top #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ADDR_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [ADDR_BITS-1:0]          i_req_size,
    input  logic [ADDR_BITS-1:0]          i_req_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffra_pkg::STATUS_W-1:0] o_status,
    output logic [ADDR_BITS-1:0]          o_alloc_addr,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ADDR_BITS:0]            i_pool_size
);
    import ffra_pkg::*;

    t_cmd                 w_cmd;
    t_stat                w_stat;
    logic                 w_out_free;
    logic [STATUS_W-1:0]  w_res_status;
    logic [ADDR_BITS-1:0] w_res_addr;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [ADDR_BITS-1:0] r_out_addr;

    assign w_out_free = !r_out_valid || i_out_ready;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_out_free  (w_out_free),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    ffra_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_kind       (i_kind),
        .i_req_size   (i_req_size),
        .i_req_addr   (i_req_addr),
        .i_pool_size  (i_pool_size),
        .o_res_status (w_res_status),
        .o_res_addr   (w_res_addr)
    );

    // Result register: load on hand-off, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_status <= w_res_status;
            r_out_addr   <= w_res_addr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_alloc_addr = r_out_addr;

    // A request transfer makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one still in work");

endmodule

### sim/tb_first_fit_region_allocator_top.sv
// Testbench for the first-fit region allocator: directed and randomized requests checked against a table model.
module tb_first_fit_region_allocator_top;
    import ffra_pkg::*;

    localparam int TABLE_ENTRIES = 8;
    localparam int ADDR_BITS     = 16;
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_FREE   = 1'b1;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 57;
    localparam int TIMEOUT_UNITS = 2000000;

    // Table model: sorted free regions plus the results still to come out of the block.
    class free_region_scoreboard;
        logic [16:0] pool_len;
        logic [15:0] reg_start [TABLE_ENTRIES];
        logic [16:0] reg_len   [TABLE_ENTRIES];
        logic [2:0]  status_due [$];
        logic [15:0] addr_due   [$];
        int          mismatches;

        function new();
            mismatches = 0;
            set_pool(17'd65536);
        endfunction

        // Saturate the pool size and reload one free region covering the pool
        function void set_pool(logic [16:0] value);
            logic [16:0] v;
            v = value;
            if (v == 17'd0) v = 17'd1;
            if (v > 17'd65536) v = 17'd65536;
            pool_len = v;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                reg_start[i] = '0;
                reg_len[i]   = '0;
            end
            reg_len[0] = pool_len;
        endfunction

        function int live_entries();
            int n;
            n = 0;
            while (n < TABLE_ENTRIES && reg_len[n] != '0) n++;
            return n;
        endfunction

        // Close the gap left by entry idx
        function void remove_entry(int idx, int count);
            for (int i = idx; i + 1 < count; i++) begin
                reg_start[i] = reg_start[i + 1];
                reg_len[i]   = reg_len[i + 1];
            end
            reg_start[count - 1] = '0;
            reg_len[count - 1]   = '0;
        endfunction

        // Allocate from the first region that is large enough
        function logic [2:0] take_region(logic [15:0] size, output logic [15:0] start);
            int count;
            count = live_entries();
            start = '0;
            if ({1'b0, size} >= pool_len) return ST_SIZE;
            for (int i = 0; i < count; i++) begin
                if (reg_len[i] >= {1'b0, size}) begin
                    start        = reg_start[i];
                    reg_start[i] = reg_start[i] + size;
                    reg_len[i]   = reg_len[i] - {1'b0, size};
                    if (reg_len[i] == '0) remove_entry(i, count);
                    return ST_OK;
                end
            end
            return ST_NOFIT;
        endfunction

        // Give a region back: coalesce with neighbors or insert in order
        function logic [2:0] give_region(logic [15:0] size, logic [15:0] start);
            int          count;
            int          i;
            bit          has_next;
            logic [17:0] span_end;
            logic [17:0] prev_end;
            count    = live_entries();
            i        = 0;
            span_end = {2'b00, start} + {2'b00, size};
            if ({1'b0, start} >= pool_len) return ST_ADDR;
            if (span_end > {1'b0, pool_len}) return ST_SIZE;
            while (i < count && reg_start[i] <= start) i++;
            has_next = (i < count);
            if (i > 0) begin
                prev_end = {2'b00, reg_start[i - 1]} + {1'b0, reg_len[i - 1]};
                if (prev_end == {2'b00, start}) begin
                    reg_len[i - 1] = reg_len[i - 1] + {1'b0, size};
                    if (has_next && span_end == {2'b00, reg_start[i]}) begin
                        reg_len[i - 1] = reg_len[i - 1] + reg_len[i];
                        remove_entry(i, count);
                    end
                    return ST_OK;
                end
            end
            if (has_next && span_end == {2'b00, reg_start[i]}) begin
                reg_start[i] = reg_start[i] - size;
                reg_len[i]   = reg_len[i] + {1'b0, size};
                return ST_OK;
            end
            if (size == '0) return ST_OK;
            if (count >= TABLE_ENTRIES) return ST_FULL;
            for (int k = count; k > i; k--) begin
                reg_start[k] = reg_start[k - 1];
                reg_len[k]   = reg_len[k - 1];
            end
            reg_start[i] = start;
            reg_len[i]   = {1'b0, size};
            return ST_OK;
        endfunction

        // Apply one accepted request and queue its expected result
        function void note_request(logic kind, logic [15:0] size, logic [15:0] addr,
                                   output logic [2:0] status, output logic [15:0] start);
            start = '0;
            if (kind == KIND_ALLOC) status = take_region(size, start);
            else status = give_region(size, addr);
            if (status != ST_OK) start = '0;
            status_due.push_back(status);
            addr_due.push_back(start);
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 100) $display("%0t mismatch: %s", $time, what);
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [2:0] status, logic [15:0] start);
            logic [2:0]  want_status;
            logic [15:0] want_start;
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing due: status %0d addr %0d",
                                          status, start));
                return;
            end
            want_status = status_due.pop_front();
            want_start  = addr_due.pop_front();
            if (status !== want_status)
                report_mismatch($sformatf("status %0d, want %0d", status, want_status));
            if (start !== want_start)
                report_mismatch($sformatf("alloc_addr %0d, want %0d", start, want_start));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind      = 1'b0;
    logic [15:0]          i_req_size  = '0;
    logic [15:0]          i_req_addr  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [15:0]          o_alloc_addr;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [16:0]          i_pool_size = '0;

    free_region_scoreboard sb;
    bit                    steady_phase = 1'b0;
    int                    held_addr [$];
    int                    held_size [$];

    first_fit_region_allocator_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_req_size  (i_req_size),
        .i_req_addr  (i_req_addr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_alloc_addr(o_alloc_addr),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_pool_size (i_pool_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !steady_phase && ($urandom_range(0, 99) < 23);
    endfunction

    // Check result transfers, then roll the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_status, o_alloc_addr);
        i_out_ready <= !take_break();
    end

    // Drive one request until its transfer; keep valid high when no gap follows
    task automatic send_request(input logic kind, input logic [15:0] size,
                                input logic [15:0] addr);
        logic [2:0]  status;
        logic [15:0] start;
        if (take_break()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (take_break());
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_req_size <= size;
        i_req_addr <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(kind, size, addr, status, start);
        if (kind == KIND_ALLOC && status == ST_OK && size != '0) begin
            held_addr.push_back(int'(start));
            held_size.push_back(int'(size));
        end
    endtask

    // Wait for the block to drain, then write the pool size
    task automatic write_pool_size(input logic [16:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_pool_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_pool(value);
        held_addr.delete();
        held_size.delete();
    endtask

    // Mostly alloc/free pairs over held regions, plus partial frees and raw noise
    task automatic random_request(output logic kind, output logic [15:0] size,
                                  output logic [15:0] addr);
        int p;
        int pick;
        int s;
        int idx;
        int off;
        int hs;
        p    = int'(sb.pool_len);
        pick = $urandom_range(0, 99);
        kind = KIND_ALLOC;
        size = '0;
        addr = 16'($urandom);
        if (pick < 8) begin
            kind = 1'($urandom);
            size = 16'($urandom);
        end else if (pick < 52 || held_addr.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) s = $urandom_range(0, (p > 8) ? p / 8 : 1);
            else if (pick < 90) s = p - 2 + int'($urandom_range(0, 3));
            else s = $urandom_range(0, 65535);
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
            size = 16'(s);
        end else begin
            kind = KIND_FREE;
            pick = $urandom_range(0, 99);
            if (held_addr.size() != 0 && pick < 80) begin
                idx  = $urandom_range(0, held_addr.size() - 1);
                hs   = held_size[idx];
                addr = 16'(held_addr[idx]);
                size = 16'(hs);
                if (pick >= 65 && hs > 1) begin
                    off  = $urandom_range(0, hs - 1);
                    addr = 16'(held_addr[idx] + off);
                    size = 16'($urandom_range(1, hs - off));
                end
                held_addr.delete(idx);
                held_size.delete(idx);
            end else begin
                addr = 16'($urandom_range(0, p - 1));
                size = 16'($urandom_range(0, 64));
            end
        end
    endtask

    initial begin
        logic        kind;
        logic [15:0] size;
        logic [15:0] addr;
        logic [16:0] pool_value;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pool: largest allocation, zero-size allocation, empty table, merges
        send_request(KIND_ALLOC, 16'd0, 16'd0);
        send_request(KIND_ALLOC, 16'd65535, 16'hFFFF);
        send_request(KIND_ALLOC, 16'd1, 16'd0);
        send_request(KIND_ALLOC, 16'd0, 16'd0);
        send_request(KIND_FREE, 16'd65535, 16'd65535);
        send_request(KIND_FREE, 16'd65535, 16'd0);
        send_request(KIND_FREE, 16'd1, 16'd65535);

        // Small pool: range errors, fill the table, overflow it, coalesce both sides
        write_pool_size(17'd100);
        send_request(KIND_ALLOC, 16'd100, 16'd0);
        send_request(KIND_FREE, 16'd1, 16'hFFFF);
        send_request(KIND_FREE, 16'd2, 16'd99);
        send_request(KIND_ALLOC, 16'd99, 16'd0);
        send_request(KIND_ALLOC, 16'd1, 16'd0);
        for (int j = 0; j < TABLE_ENTRIES; j++) send_request(KIND_FREE, 16'd5, 16'(j * 10));
        send_request(KIND_FREE, 16'd5, 16'd80);
        send_request(KIND_FREE, 16'd0, 16'd90);
        send_request(KIND_FREE, 16'd5, 16'd0);
        send_request(KIND_FREE, 16'd5, 16'd5);
        send_request(KIND_ALLOC, 16'd0, 16'd0);

        // Random phases over several pool sizes, extremes and saturation included
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: pool_value = 17'd0;
                1: pool_value = 17'h1FFFF;
                2: pool_value = 17'd64;
                3: pool_value = 17'd2;
                4: pool_value = 17'($urandom_range(1, 65536));
                5: pool_value = 17'd65536;
                default: pool_value = 17'd1000;
            endcase
            write_pool_size(pool_value);
            steady_phase <= (phase == 2);
            repeat (PHASE_ITEMS) begin
                random_request(kind, size, addr);
                send_request(kind, size, addr);
            end
        end

        // Drain and report
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #TIMEOUT_UNITS;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### first_fit_region_allocator_top.f
rtl/ffra_pkg.sv
rtl/ffra_ctrl.sv
rtl/ffra_dp.sv
rtl/first_fit_region_allocator_top.sv
sim/tb_first_fit_region_allocator_top.sv
